FILE: rtl/core/rvdec_pkg.sv
// shared types, opcode constants and result codes of the rv32im decoder
`timescale 1ns / 1ps

package rvdec_pkg;

	// base opcodes
	localparam logic [6:0] OP_LOAD   = 7'b0000011;
	localparam logic [6:0] OP_CUSTOM = 7'b0001011;
	localparam logic [6:0] OP_FENCE  = 7'b0001111;
	localparam logic [6:0] OP_AUIPC  = 7'b0010111;
	localparam logic [6:0] OP_LUI    = 7'b0110111;
	localparam logic [6:0] OP_REG    = 7'b0110011;
	localparam logic [6:0] OP_IMM    = 7'b0010011;
	localparam logic [6:0] OP_JALR   = 7'b1100111;
	localparam logic [6:0] OP_STORE  = 7'b0100011;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;
	localparam logic [6:0] OP_JAL    = 7'b1101111;
	localparam logic [6:0] OP_SYSTEM = 7'b1110011;

	// opcode class carried from the first stage
	typedef enum logic [3:0] {
		OPC_NONE,
		OPC_LOAD,
		OPC_CUSTOM,
		OPC_FENCE,
		OPC_AUIPC,
		OPC_LUI,
		OPC_REG,
		OPC_IMM,
		OPC_JALR,
		OPC_STORE,
		OPC_BRANCH,
		OPC_JAL,
		OPC_SYSTEM
	} opc_t;

	// funct7 values of the register ops
	localparam logic [6:0] F7_BASE   = 7'h00;
	localparam logic [6:0] F7_ALT    = 7'h20;
	localparam logic [6:0] F7_MULDIV = 7'h01;

	// funct12 values of the system traps and returns
	localparam logic [11:0] F12_ECALL  = 12'h000;
	localparam logic [11:0] F12_EBREAK = 12'h001;
	localparam logic [11:0] F12_URET   = 12'h002;
	localparam logic [11:0] F12_SRET   = 12'h102;
	localparam logic [11:0] F12_MRET   = 12'h302;

	// funct3 values that need a name
	localparam logic [2:0] F3_ZERO  = 3'd0;
	localparam logic [2:0] F3_ONE   = 3'd1;
	localparam logic [2:0] F3_TWO   = 3'd2;
	localparam logic [2:0] F3_THREE = 3'd3;
	localparam logic [2:0] F3_FOUR  = 3'd4;
	localparam logic [2:0] F3_FIVE  = 3'd5;
	localparam logic [2:0] F3_SIX   = 3'd6;
	localparam logic [2:0] F3_SEVEN = 3'd7;

	localparam logic [4:0] RS2_EXTX = 5'd0;
	localparam logic [4:0] RS2_EXT  = 5'd1;

	// instruction formats
	typedef logic [2:0] fmt_t;
	localparam fmt_t FMT_I = 3'd0;
	localparam fmt_t FMT_U = 3'd1;
	localparam fmt_t FMT_R = 3'd2;
	localparam fmt_t FMT_S = 3'd3;
	localparam fmt_t FMT_B = 3'd4;
	localparam fmt_t FMT_J = 3'd5;

	// dense mnemonic codes
	typedef logic [5:0] kind_t;
	localparam kind_t K_LB     = 6'd0;
	localparam kind_t K_LH     = 6'd1;
	localparam kind_t K_LW     = 6'd2;
	localparam kind_t K_LBU    = 6'd3;
	localparam kind_t K_LHU    = 6'd4;
	localparam kind_t K_EXTX   = 6'd5;
	localparam kind_t K_EXT    = 6'd6;
	localparam kind_t K_ADDI   = 6'd7;
	localparam kind_t K_AUIPC  = 6'd8;
	localparam kind_t K_ADD    = 6'd9;
	localparam kind_t K_SUB    = 6'd10;
	localparam kind_t K_SLL    = 6'd11;
	localparam kind_t K_SLT    = 6'd12;
	localparam kind_t K_SLTU   = 6'd13;
	localparam kind_t K_SRL    = 6'd14;
	localparam kind_t K_SRA    = 6'd15;
	localparam kind_t K_OR     = 6'd16;
	localparam kind_t K_AND    = 6'd17;
	localparam kind_t K_MUL    = 6'd18;
	localparam kind_t K_MULH   = 6'd19;
	localparam kind_t K_MULHSU = 6'd20;
	localparam kind_t K_MULHU  = 6'd21;
	localparam kind_t K_XOR    = 6'd22;
	localparam kind_t K_DIV    = 6'd23;
	localparam kind_t K_DIVU   = 6'd24;
	localparam kind_t K_REM    = 6'd25;
	localparam kind_t K_REMU   = 6'd26;
	localparam kind_t K_SLTI   = 6'd27;
	localparam kind_t K_SLTIU  = 6'd28;
	localparam kind_t K_XORI   = 6'd29;
	localparam kind_t K_ORI    = 6'd30;
	localparam kind_t K_ANDI   = 6'd31;
	localparam kind_t K_SLLI   = 6'd32;
	localparam kind_t K_SRLI   = 6'd33;
	localparam kind_t K_SRAI   = 6'd34;
	localparam kind_t K_LUI    = 6'd35;
	localparam kind_t K_JALR   = 6'd36;
	localparam kind_t K_SB     = 6'd37;
	localparam kind_t K_SH     = 6'd38;
	localparam kind_t K_SW     = 6'd39;
	localparam kind_t K_BEQ    = 6'd40;
	localparam kind_t K_BNE    = 6'd41;
	localparam kind_t K_BLT    = 6'd42;
	localparam kind_t K_BGE    = 6'd43;
	localparam kind_t K_BLTU   = 6'd44;
	localparam kind_t K_BGEU   = 6'd45;
	localparam kind_t K_JAL    = 6'd46;
	localparam kind_t K_ECALL  = 6'd47;
	localparam kind_t K_EBREAK = 6'd48;
	localparam kind_t K_URET   = 6'd49;
	localparam kind_t K_SRET   = 6'd50;
	localparam kind_t K_MRET   = 6'd51;
	localparam kind_t K_CSRRW  = 6'd52;
	localparam kind_t K_CSRRS  = 6'd53;
	localparam kind_t K_CSRRC  = 6'd54;
	localparam kind_t K_CSRRWI = 6'd55;
	localparam kind_t K_CSRRSI = 6'd56;
	localparam kind_t K_CSRRCI = 6'd57;

	localparam int WORD_W = 32;
	localparam int REG_W  = 5;
	localparam int IMM_W  = 21;

	// immediate layout picked in the second stage
	typedef enum logic [2:0] {
		IMM_NONE,
		IMM_I,
		IMM_SH,
		IMM_U,
		IMM_S,
		IMM_B,
		IMM_J
	} imm_sel_t;

	// first stage to second stage
	typedef struct packed {
		logic [WORD_W-1:0] word;
		opc_t              opc;
	} s1_t;

	// second stage to third stage
	typedef struct packed {
		logic              ok;
		fmt_t              fmt;
		kind_t             kind;
		logic              use_rd;
		logic              use_rs1;
		logic              use_rs2;
		imm_sel_t          imm_sel;
		logic [WORD_W-1:0] word;
	} s2_t;

endpackage

FILE: rtl/core/rvdec_field_stage.sv
// first stage: instruction word register and opcode classification
`timescale 1ns / 1ps

module rvdec_field_stage (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [rvdec_pkg::WORD_W-1:0]     in_word,
	output logic                             up_ready,
	input  logic                             dn_ready,
	output logic                             out_valid,
	output rvdec_pkg::s1_t                   out_data
);

	logic           v_s1;
	rvdec_pkg::s1_t data_s1;
	rvdec_pkg::opc_t opc;

	assign up_ready = !v_s1 || dn_ready;

	always_comb begin
		unique case (in_word[6:0])
			rvdec_pkg::OP_LOAD:   opc = rvdec_pkg::OPC_LOAD;
			rvdec_pkg::OP_CUSTOM: opc = rvdec_pkg::OPC_CUSTOM;
			rvdec_pkg::OP_FENCE:  opc = rvdec_pkg::OPC_FENCE;
			rvdec_pkg::OP_AUIPC:  opc = rvdec_pkg::OPC_AUIPC;
			rvdec_pkg::OP_LUI:    opc = rvdec_pkg::OPC_LUI;
			rvdec_pkg::OP_REG:    opc = rvdec_pkg::OPC_REG;
			rvdec_pkg::OP_IMM:    opc = rvdec_pkg::OPC_IMM;
			rvdec_pkg::OP_JALR:   opc = rvdec_pkg::OPC_JALR;
			rvdec_pkg::OP_STORE:  opc = rvdec_pkg::OPC_STORE;
			rvdec_pkg::OP_BRANCH: opc = rvdec_pkg::OPC_BRANCH;
			rvdec_pkg::OP_JAL:    opc = rvdec_pkg::OPC_JAL;
			rvdec_pkg::OP_SYSTEM: opc = rvdec_pkg::OPC_SYSTEM;
			default:              opc = rvdec_pkg::OPC_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (up_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && in_valid) begin
			data_s1.word <= in_word;
			data_s1.opc  <= opc;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = data_s1;

endmodule

FILE: rtl/core/rvdec_kind_stage.sv
// second stage: format, mnemonic code, register use and immediate layout
`timescale 1ns / 1ps

module rvdec_kind_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  rvdec_pkg::s1_t in_data,
	output logic           up_ready,
	input  logic           dn_ready,
	output logic           out_valid,
	output rvdec_pkg::s2_t out_data
);

	logic           v_s2;
	rvdec_pkg::s2_t data_s2;
	rvdec_pkg::s2_t d;
	logic [2:0]     f3;
	logic [6:0]     f7;
	logic [4:0]     rs2f;
	logic [11:0]    f12;

	assign up_ready = !v_s2 || dn_ready;

	assign f3   = in_data.word[14:12];
	assign f7   = in_data.word[31:25];
	assign rs2f = in_data.word[24:20];
	assign f12  = in_data.word[31:20];

	always_comb begin
		d         = '0;
		d.word    = in_data.word;
		d.imm_sel = rvdec_pkg::IMM_NONE;
		unique case (in_data.opc)
			rvdec_pkg::OPC_LOAD: begin
				d.ok = 1'b1;
				unique case (f3)
					rvdec_pkg::F3_ZERO: d.kind = rvdec_pkg::K_LB;
					rvdec_pkg::F3_ONE:  d.kind = rvdec_pkg::K_LH;
					rvdec_pkg::F3_TWO:  d.kind = rvdec_pkg::K_LW;
					rvdec_pkg::F3_FOUR: d.kind = rvdec_pkg::K_LBU;
					rvdec_pkg::F3_FIVE: d.kind = rvdec_pkg::K_LHU;
					default:            d.ok   = 1'b0;
				endcase
				d.fmt     = rvdec_pkg::FMT_I;
				d.use_rd  = 1'b1;
				d.use_rs1 = 1'b1;
				d.imm_sel = rvdec_pkg::IMM_I;
			end
			rvdec_pkg::OPC_CUSTOM: begin
				d.fmt = rvdec_pkg::FMT_I;
				if (rs2f == rvdec_pkg::RS2_EXTX) begin
					d.ok   = 1'b1;
					d.kind = rvdec_pkg::K_EXTX;
				end else if (rs2f == rvdec_pkg::RS2_EXT) begin
					d.ok   = 1'b1;
					d.kind = rvdec_pkg::K_EXT;
				end
			end
			rvdec_pkg::OPC_FENCE: begin
				// fence and fence.i look like addi with a zero immediate
				d.ok      = (f3 == rvdec_pkg::F3_ZERO) || (f3 == rvdec_pkg::F3_ONE);
				d.fmt     = rvdec_pkg::FMT_I;
				d.kind    = rvdec_pkg::K_ADDI;
				d.use_rd  = 1'b1;
				d.use_rs1 = 1'b1;
			end
			rvdec_pkg::OPC_AUIPC: begin
				d.ok      = 1'b1;
				d.fmt     = rvdec_pkg::FMT_U;
				d.kind    = rvdec_pkg::K_AUIPC;
				d.use_rd  = 1'b1;
				d.imm_sel = rvdec_pkg::IMM_U;
			end
			rvdec_pkg::OPC_LUI: begin
				d.ok      = 1'b1;
				d.fmt     = rvdec_pkg::FMT_U;
				d.kind    = rvdec_pkg::K_LUI;
				d.use_rd  = 1'b1;
				d.imm_sel = rvdec_pkg::IMM_U;
			end
			rvdec_pkg::OPC_REG: begin
				d.ok = 1'b1;
				priority if (f7 == rvdec_pkg::F7_BASE) begin
					unique case (f3)
						rvdec_pkg::F3_ZERO:  d.kind = rvdec_pkg::K_ADD;
						rvdec_pkg::F3_ONE:   d.kind = rvdec_pkg::K_SLL;
						rvdec_pkg::F3_TWO:   d.kind = rvdec_pkg::K_SLT;
						rvdec_pkg::F3_THREE: d.kind = rvdec_pkg::K_SLTU;
						rvdec_pkg::F3_FOUR:  d.kind = rvdec_pkg::K_XOR;
						rvdec_pkg::F3_FIVE:  d.kind = rvdec_pkg::K_SRL;
						rvdec_pkg::F3_SIX:   d.kind = rvdec_pkg::K_OR;
						default:             d.kind = rvdec_pkg::K_AND;
					endcase
				end else if (f7 == rvdec_pkg::F7_ALT && f3 == rvdec_pkg::F3_ZERO) begin
					d.kind = rvdec_pkg::K_SUB;
				end else if (f7 == rvdec_pkg::F7_ALT && f3 == rvdec_pkg::F3_FIVE) begin
					d.kind = rvdec_pkg::K_SRA;
				end else if (f7 == rvdec_pkg::F7_MULDIV) begin
					unique case (f3)
						rvdec_pkg::F3_ZERO:  d.kind = rvdec_pkg::K_MUL;
						rvdec_pkg::F3_ONE:   d.kind = rvdec_pkg::K_MULH;
						rvdec_pkg::F3_TWO:   d.kind = rvdec_pkg::K_MULHSU;
						rvdec_pkg::F3_THREE: d.kind = rvdec_pkg::K_MULHU;
						rvdec_pkg::F3_FOUR:  d.kind = rvdec_pkg::K_DIV;
						rvdec_pkg::F3_FIVE:  d.kind = rvdec_pkg::K_DIVU;
						rvdec_pkg::F3_SIX:   d.kind = rvdec_pkg::K_REM;
						default:             d.kind = rvdec_pkg::K_REMU;
					endcase
				end else begin
					d.ok = 1'b0;
				end
				d.fmt     = rvdec_pkg::FMT_R;
				d.use_rd  = 1'b1;
				d.use_rs1 = 1'b1;
				d.use_rs2 = 1'b1;
			end
			rvdec_pkg::OPC_IMM: begin
				d.ok      = 1'b1;
				d.fmt     = rvdec_pkg::FMT_I;
				d.use_rd  = 1'b1;
				d.use_rs1 = 1'b1;
				d.imm_sel = rvdec_pkg::IMM_I;
				unique case (f3)
					rvdec_pkg::F3_ZERO:  d.kind = rvdec_pkg::K_ADDI;
					rvdec_pkg::F3_ONE:   d.kind = rvdec_pkg::K_SLLI;
					rvdec_pkg::F3_TWO:   d.kind = rvdec_pkg::K_SLTI;
					rvdec_pkg::F3_THREE: d.kind = rvdec_pkg::K_SLTIU;
					rvdec_pkg::F3_FOUR:  d.kind = rvdec_pkg::K_XORI;
					rvdec_pkg::F3_FIVE: begin
						// right shifts keep only the shift amount
						d.kind    = (f7 == rvdec_pkg::F7_BASE) ?
							rvdec_pkg::K_SRLI : rvdec_pkg::K_SRAI;
						d.imm_sel = rvdec_pkg::IMM_SH;
					end
					rvdec_pkg::F3_SIX:   d.kind = rvdec_pkg::K_ORI;
					default:             d.kind = rvdec_pkg::K_ANDI;
				endcase
			end
			rvdec_pkg::OPC_JALR: begin
				d.ok      = 1'b1;
				d.fmt     = rvdec_pkg::FMT_I;
				d.kind    = rvdec_pkg::K_JALR;
				d.use_rd  = 1'b1;
				d.use_rs1 = 1'b1;
				d.imm_sel = rvdec_pkg::IMM_I;
			end
			rvdec_pkg::OPC_STORE: begin
				d.ok = 1'b1;
				unique case (f3)
					rvdec_pkg::F3_ZERO: d.kind = rvdec_pkg::K_SB;
					rvdec_pkg::F3_ONE:  d.kind = rvdec_pkg::K_SH;
					rvdec_pkg::F3_TWO:  d.kind = rvdec_pkg::K_SW;
					default:            d.ok   = 1'b0;
				endcase
				d.fmt     = rvdec_pkg::FMT_S;
				d.use_rs1 = 1'b1;
				d.use_rs2 = 1'b1;
				d.imm_sel = rvdec_pkg::IMM_S;
			end
			rvdec_pkg::OPC_BRANCH: begin
				d.ok = 1'b1;
				unique case (f3)
					rvdec_pkg::F3_ZERO:  d.kind = rvdec_pkg::K_BEQ;
					rvdec_pkg::F3_ONE:   d.kind = rvdec_pkg::K_BNE;
					rvdec_pkg::F3_FOUR:  d.kind = rvdec_pkg::K_BLT;
					rvdec_pkg::F3_FIVE:  d.kind = rvdec_pkg::K_BGE;
					rvdec_pkg::F3_SIX:   d.kind = rvdec_pkg::K_BLTU;
					rvdec_pkg::F3_SEVEN: d.kind = rvdec_pkg::K_BGEU;
					default:             d.ok   = 1'b0;
				endcase
				d.fmt     = rvdec_pkg::FMT_B;
				d.use_rs1 = 1'b1;
				d.use_rs2 = 1'b1;
				d.imm_sel = rvdec_pkg::IMM_B;
			end
			rvdec_pkg::OPC_JAL: begin
				d.ok      = 1'b1;
				d.fmt     = rvdec_pkg::FMT_J;
				d.kind    = rvdec_pkg::K_JAL;
				d.use_rd  = 1'b1;
				d.imm_sel = rvdec_pkg::IMM_J;
			end
			rvdec_pkg::OPC_SYSTEM: begin
				d.ok      = 1'b1;
				d.fmt     = rvdec_pkg::FMT_I;
				d.use_rd  = 1'b1;
				d.use_rs1 = 1'b1;
				d.imm_sel = rvdec_pkg::IMM_I;
				unique case (f3)
					rvdec_pkg::F3_ZERO: begin
						// returns and traps chosen by funct12 alone
						priority if (f12 == rvdec_pkg::F12_ECALL)  d.kind = rvdec_pkg::K_ECALL;
						else if (f12 == rvdec_pkg::F12_EBREAK)     d.kind = rvdec_pkg::K_EBREAK;
						else if (f12 == rvdec_pkg::F12_URET)       d.kind = rvdec_pkg::K_URET;
						else if (f12 == rvdec_pkg::F12_SRET)       d.kind = rvdec_pkg::K_SRET;
						else if (f12 == rvdec_pkg::F12_MRET)       d.kind = rvdec_pkg::K_MRET;
						else                                       d.ok   = 1'b0;
					end
					rvdec_pkg::F3_ONE:   d.kind = rvdec_pkg::K_CSRRW;
					rvdec_pkg::F3_TWO:   d.kind = rvdec_pkg::K_CSRRS;
					rvdec_pkg::F3_THREE: d.kind = rvdec_pkg::K_CSRRC;
					rvdec_pkg::F3_FIVE:  d.kind = rvdec_pkg::K_CSRRWI;
					rvdec_pkg::F3_SIX:   d.kind = rvdec_pkg::K_CSRRSI;
					rvdec_pkg::F3_SEVEN: d.kind = rvdec_pkg::K_CSRRCI;
					default:             d.ok   = 1'b0;
				endcase
			end
			default: begin
				d.ok = 1'b0;
			end
		endcase

		// unknown encodings leave every field but the word at zero
		if (!d.ok) begin
			d         = '0;
			d.word    = in_data.word;
			d.imm_sel = rvdec_pkg::IMM_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (up_ready) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && in_valid) begin
			data_s2 <= d;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = data_s2;

endmodule

FILE: rtl/core/rvdec_out_stage.sv
// third stage: register selection, immediate assembly and result register
`timescale 1ns / 1ps

module rvdec_out_stage (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  rvdec_pkg::s2_t                  in_data,
	output logic                            up_ready,
	input  logic                            dn_ready,
	output logic                            out_valid,
	output logic                            res_ok,
	output rvdec_pkg::fmt_t                 res_fmt,
	output rvdec_pkg::kind_t                res_kind,
	output logic [rvdec_pkg::REG_W-1:0]     res_rd,
	output logic [rvdec_pkg::REG_W-1:0]     res_rs1,
	output logic [rvdec_pkg::REG_W-1:0]     res_rs2,
	output logic [rvdec_pkg::IMM_W-1:0]     res_imm
);

	logic                        v_s3;
	logic                        ok_s3;
	rvdec_pkg::fmt_t             fmt_s3;
	rvdec_pkg::kind_t            kind_s3;
	logic [rvdec_pkg::REG_W-1:0] rd_s3;
	logic [rvdec_pkg::REG_W-1:0] rs1_s3;
	logic [rvdec_pkg::REG_W-1:0] rs2_s3;
	logic [rvdec_pkg::IMM_W-1:0] imm_s3;
	logic [rvdec_pkg::IMM_W-1:0] imm;
	logic [31:0]                 w;

	assign up_ready = !v_s3 || dn_ready;
	assign w        = in_data.word;

	always_comb begin
		unique case (in_data.imm_sel)
			rvdec_pkg::IMM_I:  imm = {9'd0, w[31:20]};
			rvdec_pkg::IMM_SH: imm = {16'd0, w[24:20]};
			rvdec_pkg::IMM_U:  imm = {1'b0, w[31:12]};
			rvdec_pkg::IMM_S:  imm = {9'd0, w[31:25], w[11:7]};
			rvdec_pkg::IMM_B:  imm = {8'd0, w[31], w[7], w[30:25], w[11:8], 1'b0};
			rvdec_pkg::IMM_J:  imm = {w[31], w[19:12], w[20], w[30:21], 1'b0};
			default:           imm = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (up_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && in_valid) begin
			ok_s3   <= in_data.ok;
			fmt_s3  <= in_data.fmt;
			kind_s3 <= in_data.kind;
			rd_s3   <= in_data.use_rd  ? w[11:7]  : '0;
			rs1_s3  <= in_data.use_rs1 ? w[19:15] : '0;
			rs2_s3  <= in_data.use_rs2 ? w[24:20] : '0;
			imm_s3  <= imm;
		end
	end

	assign out_valid = v_s3;
	assign res_ok    = ok_s3;
	assign res_fmt   = fmt_s3;
	assign res_kind  = kind_s3;
	assign res_rd    = rd_s3;
	assign res_rs1   = rs1_s3;
	assign res_rs2   = rs2_s3;
	assign res_imm   = imm_s3;

endmodule

FILE: rtl/core/rv32im_instruction_decoder.sv
// top level of the three-stage rv32im instruction decoder
`timescale 1ns / 1ps

// channel   | handshake           | payload
// ----------+---------------------+--------------------------------------------
// input     | in_valid, in_ready  | instr_word
// output    | out_valid, out_ready| valid_res, format, kind, dest_reg,
//           |                     | src_reg_a, src_reg_b, immediate
//
// one transfer per cycle in each direction while the output is not stalled; a
// word's result is registered in turn by the opcode class, kind decode and
// result stages before out_valid shows it
// reset clears the three stage valid bits only; the data registers hold junk
// a stalled output holds its result; each stage refills as soon as the stage
// ahead of it moves, so in_ready drops only when all three stages are full

module rv32im_instruction_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rvdec_pkg::WORD_W-1:0]    instr_word,
	// output channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            valid_res,
	output logic [2:0]                      format,
	output logic [5:0]                      kind,
	output logic [rvdec_pkg::REG_W-1:0]     dest_reg,
	output logic [rvdec_pkg::REG_W-1:0]     src_reg_a,
	output logic [rvdec_pkg::REG_W-1:0]     src_reg_b,
	output logic [rvdec_pkg::IMM_W-1:0]     immediate
);

	// stage to stage valid/ready and payload
	logic           v1;
	logic           v2;
	logic           rdy2;
	logic           rdy3;
	rvdec_pkg::s1_t d1;
	rvdec_pkg::s2_t d2;

	// stage 1: register the word and classify the opcode
	rvdec_field_stage u_field (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_word   (instr_word),
		.up_ready  (in_ready),
		.dn_ready  (rdy2),
		.out_valid (v1),
		.out_data  (d1)
	);

	// stage 2: mnemonic, format and which fields carry through
	rvdec_kind_stage u_kind (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_data   (d1),
		.up_ready  (rdy2),
		.dn_ready  (rdy3),
		.out_valid (v2),
		.out_data  (d2)
	);

	// stage 3: field masking, immediate assembly, output register
	rvdec_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_data   (d2),
		.up_ready  (rdy3),
		.dn_ready  (out_ready),
		.out_valid (out_valid),
		.res_ok    (valid_res),
		.res_fmt   (format),
		.res_kind  (kind),
		.res_rd    (dest_reg),
		.res_rs1   (src_reg_a),
		.res_rs2   (src_reg_b),
		.res_imm   (immediate)
	);

	// an unknown encoding carries nothing but zeros
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !valid_res) |-> (format == '0 && kind == '0 &&
			dest_reg == '0 && src_reg_a == '0 && src_reg_b == '0 && immediate == '0))
		else $error("unknown encoding with nonzero fields");

	// register ops carry no immediate
	a_reg_no_imm: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && valid_res && format == rvdec_pkg::FMT_R) |-> immediate == '0)
		else $error("register op with immediate");

	// stores and branches have no destination
	a_sb_no_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && valid_res &&
			(format == rvdec_pkg::FMT_S || format == rvdec_pkg::FMT_B)) |-> dest_reg == '0)
		else $error("store or branch with destination");

	// upper-immediate and jump formats read no sources
	a_uj_no_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && valid_res &&
			(format == rvdec_pkg::FMT_U || format == rvdec_pkg::FMT_J)) |->
			(src_reg_a == '0 && src_reg_b == '0))
		else $error("u or j format with source registers");

	// backpressure reaches the input only when the whole pipe is full and stalled
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready && v1 && v2))
		else $error("input stalled with room in the pipe");

endmodule
